>>> hw/rtl/lfida_pkg.sv
// ----------------------------------------------------------------------------
// lfida_pkg
// shared types and constants of the lowest free id bitmap allocator
// ----------------------------------------------------------------------------
`default_nettype none

package lfida_pkg;

   localparam int unsigned ID_W     = 16;
   localparam int unsigned COUNT_W  = 14;
   localparam int unsigned WORD_W   = 32;
   localparam int unsigned WORD_LOG = 5;

   typedef enum logic {
      CMD_ALLOC   = 1'b0,
      CMD_RELEASE = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      STATUS_ALLOCATED     = 3'd0,
      STATUS_RELEASED      = 3'd1,
      STATUS_FULL          = 3'd2,
      STATUS_OUT_OF_RANGE  = 3'd3,
      STATUS_NOT_ALLOCATED = 3'd4
   } status_type;

   typedef enum logic {
      CSR_BASE_ID  = 1'b0,
      CSR_ID_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_REL_CHK,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

>>> hw/rtl/lfida_if.sv
// ----------------------------------------------------------------------------
// lfida request and response channels
// valid/ready channels carrying allocator requests and responses
// ----------------------------------------------------------------------------
`default_nettype none

interface lfida_req_if;
   import lfida_pkg::*;

   logic               valid;
   logic               ready;
   cmd_type            cmd;
   logic [ID_W-1:0]    release_id;

   modport source (output valid, output cmd, output release_id, input ready);
   modport sink   (input valid, input cmd, input release_id, output ready);
endinterface

interface lfida_rsp_if;
   import lfida_pkg::*;

   logic               valid;
   logic               ready;
   logic [ID_W-1:0]    result_id;
   status_type         status;

   modport source (output valid, output result_id, output status, input ready);
   modport sink   (input valid, input result_id, input status, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/lowest_free_id_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// lowest_free_id_bitmap_allocator
// Hands out the lowest free id in [base_id, base_id + id_count - 1] (count
// cut to ID_COUNT and the id space); takes ids back, one used mark per slot.
//
// req_chan carries a request (allocate, or release of release_id); rsp_chan
// returns exactly one response (result_id, status) per request, in order.
// csr_we / csr_index / csr_wdata write base_id (index 0) and id_count
// (index 1); write only while no request is outstanding.
// The used-mark bitmap sits in a one-read one-write memory of 32-bit words
// with a registered read; an allocate scans it one word per clock.
// Release: ST_REL_CHK tests and clears the mark, then ST_DONE loads the
// response. Allocate: ST_SCAN reads up to ceil(active slots / 32) words (none
// for an empty range), then ST_DONE loads the response. One request is in
// flight at a time.
// After reset a clearing pass zeroes all ceil(ID_COUNT / 32) bitmap words
// with req_chan.ready low; csr writes still land.
// The response sits in an output register; while rsp_chan is stalled the
// next request is still taken and worked on, and waits only for that slot.
// ----------------------------------------------------------------------------
`default_nettype none

module lowest_free_id_bitmap_allocator #(
   parameter int unsigned ID_COUNT = 8192
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   lfida_req_if.sink                       req_chan,
   lfida_rsp_if.source                     rsp_chan,
   input  wire logic                       csr_we,
   input  wire lfida_pkg::csr_index_type   csr_index,
   input  wire logic [lfida_pkg::ID_W-1:0] csr_wdata
);
   import lfida_pkg::*;

   localparam int unsigned WORDS = (ID_COUNT + WORD_W - 1) / WORD_W;
   localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int unsigned NW    = ID_W + 1;

   // bitmap memory
   logic [WORD_W-1:0] mem_array [WORDS];
   logic [WORD_W-1:0] mem_q_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [AW-1:0]     mem_raddr;
   logic [WORD_W-1:0] mem_wdata;

   state_type           state_ff, state_in;
   logic [AW:0]         issue_ff, issue_in;
   logic [AW-1:0]       q_addr_ff, q_addr_in;
   logic [ID_W-1:0]     slot_ff, slot_in;
   logic [ID_W-1:0]     res_id_ff, res_id_in;
   status_type          res_st_ff, res_st_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;
   status_type          rsp_st_ff, rsp_st_in;
   logic [ID_W-1:0]     base_ff;
   logic [COUNT_W-1:0]  count_ff;

   logic [NW-1:0]       lim_b;
   logic [NW-1:0]       n_slots;
   logic [NW-1:0]       last_word;
   logic [NW-1:0]       rel_diff;
   logic [NW-1:0]       word_rem;
   logic [WORD_W-1:0]   word_mask;
   logic [WORD_W-1:0]   free_bits;
   logic [WORD_LOG-1:0] free_pos;
   logic [ID_W-1:0]     alloc_slot;

   function automatic logic [WORD_LOG-1:0] lowest_set(input logic [WORD_W-1:0] v);
      logic [WORD_LOG-1:0] pos;
      pos = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (v[i]) begin
            pos = WORD_LOG'(i);
         end
      end
      return pos;
   endfunction

   // active range
   always_comb begin
      lim_b   = NW'(17'h10000) - NW'(base_ff);
      n_slots = NW'(count_ff);
      if (n_slots > NW'(ID_COUNT)) begin
         n_slots = NW'(ID_COUNT);
      end
      if (n_slots > lim_b) begin
         n_slots = lim_b;
      end
      last_word  = (n_slots - NW'(1)) >> WORD_LOG;
      rel_diff   = NW'(req_chan.release_id) - NW'(base_ff);
      word_rem   = n_slots - (NW'(q_addr_ff) << WORD_LOG);
      word_mask  = (word_rem >= NW'(WORD_W)) ? '1 :
                   ((WORD_W'(1) << word_rem[WORD_LOG-1:0]) - WORD_W'(1));
      free_bits  = ~mem_q_ff & word_mask;
      free_pos   = lowest_set(free_bits);
      alloc_slot = ID_W'({q_addr_ff, free_pos});
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_array[mem_waddr] <= mem_wdata;
      end
      mem_q_ff <= mem_array[mem_raddr];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= ID_W'(300);
         count_ff <= COUNT_W'(4701);
      end else if (csr_we) begin
         case (csr_index)
            CSR_BASE_ID:  base_ff  <= csr_wdata;
            CSR_ID_COUNT: count_ff <= csr_wdata[COUNT_W-1:0];
            default:      base_ff  <= base_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         issue_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_addr_ff <= q_addr_in;
      slot_ff   <= slot_in;
      res_id_ff <= res_id_in;
      res_st_ff <= res_st_in;
      rsp_id_ff <= rsp_id_in;
      rsp_st_ff <= rsp_st_in;
   end

   always_comb begin
      state_in     = state_ff;
      issue_in     = issue_ff;
      q_addr_in    = q_addr_ff;
      slot_in      = slot_ff;
      res_id_in    = res_id_ff;
      res_st_in    = res_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_id_in    = rsp_id_ff;
      rsp_st_in    = rsp_st_ff;
      mem_we       = 1'b0;
      mem_waddr    = q_addr_ff;
      mem_wdata    = mem_q_ff;
      mem_raddr    = issue_ff[AW-1:0];

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = issue_ff[AW-1:0];
            mem_wdata = '0;
            issue_in  = issue_ff + (AW+1)'(1);
            if (issue_ff == (AW+1)'(WORDS - 1)) begin
               issue_in = '0;
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.cmd == CMD_ALLOC) begin
                  if (n_slots == '0) begin
                     res_id_in = '0;
                     res_st_in = STATUS_FULL;
                     state_in  = ST_DONE;
                  end else begin
                     mem_raddr = '0;
                     q_addr_in = '0;
                     issue_in  = (AW+1)'(1);
                     state_in  = ST_SCAN;
                  end
               end else begin
                  if (req_chan.release_id < base_ff || rel_diff >= n_slots) begin
                     res_id_in = '0;
                     res_st_in = STATUS_OUT_OF_RANGE;
                     state_in  = ST_DONE;
                  end else begin
                     slot_in   = rel_diff[ID_W-1:0];
                     mem_raddr = AW'(rel_diff >> WORD_LOG);
                     state_in  = ST_REL_CHK;
                  end
               end
            end
         end

         ST_SCAN: begin
            if (NW'(issue_ff) <= last_word) begin
               mem_raddr = issue_ff[AW-1:0];
               q_addr_in = issue_ff[AW-1:0];
               issue_in  = issue_ff + (AW+1)'(1);
            end
            if (free_bits != '0) begin
               mem_we    = 1'b1;
               mem_waddr = q_addr_ff;
               mem_wdata = mem_q_ff | (WORD_W'(1) << free_pos);
               res_id_in = base_ff + alloc_slot;
               res_st_in = STATUS_ALLOCATED;
               issue_in  = '0;
               state_in  = ST_DONE;
            end else if (NW'(q_addr_ff) == last_word) begin
               res_id_in = '0;
               res_st_in = STATUS_FULL;
               issue_in  = '0;
               state_in  = ST_DONE;
            end
         end

         ST_REL_CHK: begin
            if (mem_q_ff[slot_ff[WORD_LOG-1:0]]) begin
               mem_we    = 1'b1;
               mem_waddr = AW'(slot_ff >> WORD_LOG);
               mem_wdata = mem_q_ff & ~(WORD_W'(1) << slot_ff[WORD_LOG-1:0]);
               res_id_in = base_ff + slot_ff;
               res_st_in = STATUS_RELEASED;
            end else begin
               res_id_in = '0;
               res_st_in = STATUS_NOT_ALLOCATED;
            end
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = res_id_ff;
               rsp_st_in    = res_st_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.result_id = rsp_id_ff;
   assign rsp_chan.status    = rsp_st_ff;

endmodule

`default_nettype wire

>>> tb/sv/lfida_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lfida_checker
// Watches the request, response and csr ports of the id allocator. Keeps its
// own used-slot map and id window, works out the response to each accepted
// request, and compares every accepted response with the oldest one due.
// ----------------------------------------------------------------------------

module lfida_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  lfida_pkg::cmd_type           req_cmd,
   input  logic [lfida_pkg::ID_W-1:0]   req_release_id,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [lfida_pkg::ID_W-1:0]   rsp_result_id,
   input  lfida_pkg::status_type        rsp_status,
   input  logic                         csr_we,
   input  lfida_pkg::csr_index_type     csr_index,
   input  logic [lfida_pkg::ID_W-1:0]   csr_wdata,
   output int                           fail_count,
   output int                           pending
);
   import lfida_pkg::*;

   localparam int unsigned MAP_DEPTH      = 8192;
   localparam int unsigned RESET_BASE_ID  = 300;
   localparam int unsigned RESET_ID_COUNT = 4701;

   typedef struct packed {
      logic [ID_W-1:0] result_id;
      status_type      status;
   } answer_type;

   bit                 slot_taken [MAP_DEPTH];
   logic [ID_W-1:0]    win_base;
   logic [COUNT_W-1:0] win_count;
   answer_type         due_answers [$];

   initial fail_count = 0;

   task automatic report_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      fail_count++;
   endtask

   // slots in play: the window, clipped to the map and to the 16-bit id space
   function automatic int unsigned usable_slots();
      int unsigned n;
      n = win_count;
      if (n > MAP_DEPTH) n = MAP_DEPTH;
      if (n > 65536 - win_base) n = 65536 - win_base;
      return n;
   endfunction

   function automatic answer_type serve_request(cmd_type c, logic [ID_W-1:0] rid);
      int unsigned n;
      int unsigned slot;
      bit          found;
      answer_type  a;
      n = usable_slots();
      a.result_id = '0;
      found = 1'b0;
      if (c == CMD_ALLOC) begin
         a.status = STATUS_FULL;
         for (slot = 0; slot < n && !found; slot++) begin
            if (!slot_taken[slot]) begin
               slot_taken[slot] = 1'b1;
               a.result_id = win_base + ID_W'(slot);
               a.status = STATUS_ALLOCATED;
               found = 1'b1;
            end
         end
      end else if (rid < win_base || (rid - win_base) >= n) begin
         a.status = STATUS_OUT_OF_RANGE;
      end else begin
         slot = rid - win_base;
         if (!slot_taken[slot]) begin
            a.status = STATUS_NOT_ALLOCATED;
         end else begin
            slot_taken[slot] = 1'b0;
            a.result_id = rid;
            a.status = STATUS_RELEASED;
         end
      end
      return a;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         foreach (slot_taken[i]) slot_taken[i] = 1'b0;
         win_base = ID_W'(RESET_BASE_ID);
         win_count = COUNT_W'(RESET_ID_COUNT);
         due_answers.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_answers.size() == 0) begin
               report_mismatch($sformatf("response id %0d status %0d with none due",
                                         rsp_result_id, rsp_status));
            end else begin
               want = due_answers.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, want.status));
               if (rsp_result_id !== want.result_id)
                  report_mismatch($sformatf("result_id %0d, expected %0d",
                                            rsp_result_id, want.result_id));
            end
         end
         if (req_valid && req_ready)
            due_answers.push_back(serve_request(req_cmd, req_release_id));
         if (csr_we) begin
            if (csr_index == CSR_BASE_ID) win_base = csr_wdata;
            else win_count = csr_wdata[COUNT_W-1:0];
         end
      end
      pending <= due_answers.size();
   end

endmodule

>>> tb/sv/tb_lowest_free_id_bitmap_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lowest_free_id_bitmap_allocator
// Drives allocate and release requests through a range of id windows: a
// directed opening over the field extremes, empty and one-slot windows and
// all status codes, then random phases weighted towards the low slots so the
// map fills and churns. Both channel sides idle in random bursts; one phase
// holds the response side off for a long stretch, another drains mid-phase.
// ----------------------------------------------------------------------------

module tb_lowest_free_id_bitmap_allocator;
   import lfida_pkg::*;

   localparam int unsigned MAP_DEPTH   = 8192;
   localparam int          LONG_HOLD   = 150;
   localparam int          DRAIN_LIMIT = 20000;
   localparam int          SETTLE_CYC  = 300;

   logic               clock;
   logic               reset;
   logic               csr_we;
   csr_index_type      csr_index;
   logic [ID_W-1:0]    csr_wdata;
   int                 fail_count;
   int                 pending;
   int                 gap_pct;
   bit                 hold_off_req;

   lfida_req_if req_chan ();
   lfida_rsp_if rsp_chan ();

   lowest_free_id_bitmap_allocator #(
      .ID_COUNT (MAP_DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   lfida_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .req_cmd        (req_chan.cmd),
      .req_release_id (req_chan.release_id),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_result_id  (rsp_chan.result_id),
      .rsp_status     (rsp_chan.status),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #6_000_000;
      $display("Verification failed");
      $finish;
   end

   // response side: random stalls, plus one long hold-off on request
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_chan.ready <= 1'b1;
         end else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct / 3) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   task automatic send_req(cmd_type c, logic [ID_W-1:0] rid);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.cmd <= c;
      req_chan.release_id <= rid;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
   endtask

   // stop offering and wait for every response still due
   task automatic settle();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic open_window(logic [ID_W-1:0] b, logic [COUNT_W-1:0] c);
      settle();
      csr_we <= 1'b1;
      csr_index <= CSR_BASE_ID;
      csr_wdata <= b;
      @(posedge clock);
      csr_index <= CSR_ID_COUNT;
      csr_wdata <= ID_W'(c);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_phase(logic [ID_W-1:0] b, logic [COUNT_W-1:0] c, int items,
                            int pct, bit hold, int pause_at);
      int unsigned reach;
      int          k;
      int          roll;
      open_window(b, c);
      gap_pct = pct;
      if (hold) hold_off_req = 1'b1;
      reach = (c == 0) ? 1 : ((c > 48) ? 48 : c);
      for (k = 0; k < items; k++) begin
         if (k == pause_at) settle();
         roll = $urandom_range(0, 99);
         if (roll < 55) begin
            send_req(CMD_ALLOC, ID_W'($urandom()));
         end else if (roll < 85) begin
            send_req(CMD_RELEASE, ID_W'(b + $urandom_range(0, reach - 1)));
         end else if (roll < 93) begin
            case ($urandom_range(0, 2))
               0: send_req(CMD_RELEASE, ID_W'(b - 1));
               1: send_req(CMD_RELEASE, ID_W'(b + c));
               default: send_req(CMD_RELEASE, ID_W'(b + c - 1));
            endcase
         end else begin
            send_req(CMD_RELEASE, ID_W'($urandom()));
         end
      end
   endtask

   initial begin
      int waited;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.cmd <= CMD_ALLOC;
      req_chan.release_id <= '0;
      csr_we <= 1'b0;
      csr_index <= CSR_BASE_ID;
      csr_wdata <= '0;
      gap_pct = 10;
      hold_off_req = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // window left at its reset value
      send_req(CMD_ALLOC, 16'hFFFF);
      send_req(CMD_ALLOC, 16'h0000);
      send_req(CMD_ALLOC, ID_W'($urandom()));
      send_req(CMD_RELEASE, 16'd301);
      send_req(CMD_RELEASE, 16'd301);
      send_req(CMD_ALLOC, ID_W'($urandom()));
      send_req(CMD_RELEASE, 16'd299);
      send_req(CMD_RELEASE, 16'd5001);
      send_req(CMD_RELEASE, 16'd5000);
      send_req(CMD_RELEASE, 16'd0);
      send_req(CMD_RELEASE, 16'hFFFF);

      // top of the id space, one usable slot whose mark is still set
      open_window(16'hFFFF, 14'd8192);
      send_req(CMD_ALLOC, ID_W'($urandom()));
      send_req(CMD_RELEASE, 16'hFFFF);
      send_req(CMD_ALLOC, ID_W'($urandom()));
      send_req(CMD_ALLOC, ID_W'($urandom()));

      // empty window
      open_window(16'd0, 14'd0);
      send_req(CMD_ALLOC, ID_W'($urandom()));
      send_req(CMD_RELEASE, 16'd0);

      // high base, count beyond the map depth
      open_window(16'd57343, 14'd16383);
      send_req(CMD_ALLOC, ID_W'($urandom()));
      send_req(CMD_RELEASE, 16'd65534);
      send_req(CMD_RELEASE, 16'd57344);

      // full map from zero
      open_window(16'd0, 14'd8192);
      send_req(CMD_ALLOC, ID_W'($urandom()));
      send_req(CMD_RELEASE, 16'd8192);

      run_phase(16'd1000, 14'd16, 50, 20, 1'b0, -1);
      run_phase(16'd40000, 14'd100, 50, 5, 1'b1, -1);
      run_phase(16'd12345, 14'd3, 40, 30, 1'b0, 20);
      run_phase(16'd65500, 14'd8192, 45, 10, 1'b0, -1);
      run_phase(16'd0, 14'd1, 30, 15, 1'b0, -1);
      run_phase(16'd0, 14'd8192, 50, 20, 1'b0, -1);
      run_phase(16'd57343, 14'd8192, 45, 5, 1'b0, -1);
      run_phase(16'd20000, 14'd40, 45, 25, 1'b0, -1);
      run_phase(16'd777, 14'd24, 50, 0, 1'b0, -1);

      req_chan.valid <= 1'b0;
      waited = 0;
      do begin
         @(posedge clock);
         waited++;
      end while (pending != 0 && waited < DRAIN_LIMIT);
      repeat (SETTLE_CYC) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
